// ===== sv/radix_digit_converter_defines.svh =====
// Assertion macros for the radix digit converter checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef RADIX_DIGIT_CONVERTER_DEFINES_SVH
`define RADIX_DIGIT_CONVERTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define RDC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define RDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rdc_pkg.sv =====
// Shared constants and helpers for the radix digit converter.
// No dependencies; imported by the top level and its checker.
`default_nettype none

package rdc_pkg;

    localparam int DEFAULT_STACK_DEPTH = 32;
    localparam int DEFAULT_VALUE_WIDTH = 31;

    localparam int RADIX_W    = 5;
    localparam int DIGIT_W    = 4;
    localparam int CHAR_W     = 7;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_W-1:0] MIN_BASE    = 5'd2;
    localparam logic [RADIX_W-1:0] MAX_BASE    = 5'd16;

    // Register index, taken from paddr above the byte offset
    localparam logic [0:0] REG_RADIX = 1'b0;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'd48;
    localparam logic [CHAR_W-1:0] ASCII_A_10 = 7'd55;   // 'A' - 10

    function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] ext;
        ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        return (d < 4'd10) ? (ASCII_ZERO + ext) : (ASCII_A_10 + ext);
    endfunction

endpackage

`default_nettype wire

// ===== sv/radix_digit_converter.sv =====
// Radix digit converter: integer to base-N digits, most significant first.
// Depends on rdc_pkg; one bit-serial divider shared over all digits.
//
//  channel | handshake                      | payload
//  --------+--------------------------------+------------------------------------------
//  input   | start / busy, beat on start&!busy | i_value
//  result  | o_digit_valid, one-cycle strobe   | o_digit_value, o_digit_char, o_last_digit
//  config  | APB, write on psel&penable&pwrite | paddr, pwdata, prdata, pready
//
// Each digit comes from a restoring division over all VALUE_WIDTH quotient bits (one
// quotient bit per cycle through a 5-bit compare/subtract); once the quotient is zero,
// each digit is popped (S_POP) and driven (S_EMIT) in turn; the final digit's strobe
// shows in the first idle cycle. A zero value gives one digit. Reset is synchronous,
// active low, and leaves radix at ten. Results cannot be stalled by the receiver.
`default_nettype none

module radix_digit_converter #(
    parameter int STACK_DEPTH = rdc_pkg::DEFAULT_STACK_DEPTH,
    parameter int VALUE_WIDTH = rdc_pkg::DEFAULT_VALUE_WIDTH
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [VALUE_WIDTH-1:0]          i_value,
    output logic                                 o_digit_valid,
    output logic [rdc_pkg::DIGIT_W-1:0]          o_digit_value,
    output logic [rdc_pkg::CHAR_W-1:0]           o_digit_char,
    output logic                                 o_last_digit,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [rdc_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [rdc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [rdc_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready
);
    import rdc_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int BW = $clog2(VALUE_WIDTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_POP,
        S_EMIT
    } t_state;

    t_state                 r_state;
    logic [RADIX_W-1:0]     r_radix;
    logic [RADIX_W-1:0]     r_base;
    logic [VALUE_WIDTH-1:0] r_quot;
    logic [DIGIT_W-1:0]     r_rem;
    logic [BW-1:0]          r_bit;
    logic [CW-1:0]          r_count;
    logic [DIGIT_W-1:0]     r_stack [STACK_DEPTH];
    logic [DIGIT_W-1:0]     r_rd_digit;
    logic                   r_digit_valid;
    logic [DIGIT_W-1:0]     r_digit_value;
    logic [CHAR_W-1:0]      r_digit_char;
    logic                   r_last_digit;

    logic [RADIX_W-1:0]     w_eff_base;
    logic [RADIX_W-1:0]     w_trial;
    logic [RADIX_W-1:0]     w_diff;
    logic                   w_ge;
    logic [DIGIT_W-1:0]     n_rem;
    logic [VALUE_WIDTH-1:0] n_quot;
    logic                   w_last_step;
    logic                   w_push;
    logic [CW-1:0]          w_cnt_dec;
    logic                   w_wr;
    logic                   w_reg_hit;

    // ---------------- configuration ----------------
    assign pready    = 1'b1;
    assign w_wr      = psel && penable && pwrite;
    assign w_reg_hit = (paddr[APB_ADDR_W-1] == REG_RADIX);
    assign prdata    = w_reg_hit ? {{(APB_DATA_W-RADIX_W){1'b0}}, r_radix} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (w_wr && w_reg_hit) begin
            r_radix <= pwdata[RADIX_W-1:0];
        end
    end

    always_comb begin
        priority if (r_radix < MIN_BASE) begin
            w_eff_base = MIN_BASE;
        end else if (r_radix > MAX_BASE) begin
            w_eff_base = MAX_BASE;
        end else begin
            w_eff_base = r_radix;
        end
    end

    // ---------------- shared divider step ----------------
    // remainder stays below the base, so the shifted trial fits five bits
    assign w_trial     = {r_rem, r_quot[VALUE_WIDTH-1]};
    assign w_ge        = (w_trial >= r_base);
    assign w_diff      = w_trial - r_base;
    assign n_rem       = w_ge ? w_diff[DIGIT_W-1:0] : w_trial[DIGIT_W-1:0];
    assign n_quot      = {r_quot[VALUE_WIDTH-2:0], w_ge};
    assign w_last_step = (r_bit == BW'(VALUE_WIDTH - 1));
    // digits beyond the stack depth are the more significant ones: dropped
    assign w_push      = (r_state == S_DIV) && w_last_step && (r_count < CW'(STACK_DEPTH));
    assign w_cnt_dec   = r_count - CW'(1);

    // ---------------- digit stack ----------------
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_stack[r_count[AW-1:0]] <= n_rem;
        end
        if (r_state == S_POP) begin
            r_rd_digit <= r_stack[w_cnt_dec[AW-1:0]];
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_quot        <= '0;
            r_bit         <= '0;
            r_count       <= '0;
            r_digit_valid <= 1'b0;
        end else begin
            r_digit_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_quot  <= i_value;
                        r_rem   <= '0;
                        r_bit   <= '0;
                        r_count <= '0;
                        r_base  <= w_eff_base;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_quot <= n_quot;
                    if (w_last_step) begin
                        r_rem <= '0;
                        r_bit <= '0;
                        if (w_push) begin
                            r_count <= r_count + CW'(1);
                        end
                        if (n_quot == '0) begin
                            r_state <= S_POP;
                        end
                    end else begin
                        r_rem <= n_rem;
                        r_bit <= r_bit + BW'(1);
                    end
                end
                S_POP: begin
                    r_count <= w_cnt_dec;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    r_digit_valid <= 1'b1;
                    r_digit_value <= r_rd_digit;
                    r_digit_char  <= digit_ascii(r_rd_digit);
                    r_last_digit  <= (r_count == '0);
                    r_state       <= (r_count == '0) ? S_IDLE : S_POP;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_digit_valid = r_digit_valid;
    assign o_digit_value = r_digit_value;
    assign o_digit_char  = r_digit_char;
    assign o_last_digit  = r_last_digit;

endmodule

`default_nettype wire

// ===== sv/rdc_checker.sv =====
// Port-level checks for the radix digit converter, bound to the top level.
// Depends on rdc_pkg and radix_digit_converter_defines.svh.
`default_nettype none

`include "radix_digit_converter_defines.svh"

module rdc_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       start,
    input wire logic                       busy,
    input wire logic                       o_digit_valid,
    input wire logic [rdc_pkg::DIGIT_W-1:0] o_digit_value,
    input wire logic [rdc_pkg::CHAR_W-1:0]  o_digit_char,
    input wire logic                       o_last_digit
);
    import rdc_pkg::*;

    // an accepted beat always starts at least one division
    `RDC_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "busy not raised after accept")
    // only the final digit may come out once the block has gone idle
    `RDC_ASSERT_SAME(a_mid_digit_busy, i_clk, i_rst_n, o_digit_valid && !o_last_digit, busy, "non-final digit while idle")
    // pop and emit alternate, so strobes are never back to back
    `RDC_ASSERT_NEXT(a_strobe_gap, i_clk, i_rst_n, o_digit_valid, !o_digit_valid, "digit strobes back to back")
    `RDC_ASSERT_SAME(a_char_match, i_clk, i_rst_n, o_digit_valid, o_digit_char == digit_ascii(o_digit_value), "character does not match digit")

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_digit_valid (o_digit_valid),
    .o_digit_value (o_digit_value),
    .o_digit_char  (o_digit_char),
    .o_last_digit  (o_last_digit)
);

`default_nettype wire
